// ===== rtl/fdd_pkg.sv =====
// Package with the constants, codes and helper functions of the fixed decimal display formatter.
package fdd_pkg;

   localparam int FRACTION_BITS = 16;

   localparam int VALUE_WIDTH   = 32;
   localparam int MAG_WIDTH     = VALUE_WIDTH - 1;
   localparam int SCALE_WIDTH   = 10;
   localparam int PRODUCT_WIDTH = MAG_WIDTH + SCALE_WIDTH;
   localparam int COUNT_WIDTH   = 14;
   localparam int CHAR_WIDTH    = 8;
   localparam int LENGTH_WIDTH  = 3;
   localparam int DP_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 2;

   localparam logic [PRODUCT_WIDTH-1:0] MAX_COUNT = PRODUCT_WIDTH'(9999);

   // Reciprocal constants: floor(count * RECIP >> SHIFT) equals count / divisor
   // for every count up to 9999.
   localparam logic [13:0] RECIP_1000 = 14'd8389;
   localparam int          SHIFT_1000 = 23;
   localparam logic [13:0] RECIP_100  = 14'd5243;
   localparam int          SHIFT_100  = 19;
   localparam logic [13:0] RECIP_10   = 14'd6554;
   localparam int          SHIFT_10   = 16;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_POINT = 8'h2e;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NONE  = 8'h00;

   localparam logic [LENGTH_WIDTH-1:0] LENGTH_PLAIN = 3'd4;
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_POINT = 3'd5;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DECIMAL_POSITION = 1'b0,
      CSR_BLANK_LEADING    = 1'b1
   } csr_index_type;

   typedef enum logic [DP_WIDTH-1:0] {
      DP_NONE  = 2'd0,
      DP_ONE   = 2'd1,
      DP_TWO   = 2'd2,
      DP_THREE = 2'd3
   } dp_type;

   function automatic logic [SCALE_WIDTH-1:0] scale_of(input logic [DP_WIDTH-1:0] dp);
      logic [SCALE_WIDTH-1:0] scale;
      case (dp)
         DP_NONE:  scale = SCALE_WIDTH'(1);
         DP_ONE:   scale = SCALE_WIDTH'(10);
         DP_TWO:   scale = SCALE_WIDTH'(100);
         DP_THREE: scale = SCALE_WIDTH'(1000);
         default:  scale = SCALE_WIDTH'(1);
      endcase
      return scale;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [3:0] digit);
      return CHAR_ZERO + CHAR_WIDTH'(digit);
   endfunction

endpackage

// ===== rtl/fixed_decimal_display_formatter_core.sv =====
// Top level of the fixed decimal display formatter: a four-stage pipeline from value to text.
//
// A transaction is taken at every clock edge where start is high; busy is always low, so a
// new value may enter in every cycle. Each value produces exactly one result, shown for one
// cycle with rsp_valid high, after the value has passed the input register, scaling
// multiply, reciprocal digit split and character formatting stages. The receiver cannot stall the
// result, so it must take rsp_valid cycles as they come. Register writes on the csr_ port
// take effect at once and should be made only while no transaction is in flight.
module fixed_decimal_display_formatter_core
   import fdd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                        rsp_valid,
   output logic [CHAR_WIDTH-1:0]       rsp_text_0,
   output logic [CHAR_WIDTH-1:0]       rsp_text_1,
   output logic [CHAR_WIDTH-1:0]       rsp_text_2,
   output logic [CHAR_WIDTH-1:0]       rsp_text_3,
   output logic [CHAR_WIDTH-1:0]       rsp_text_4,
   output logic [LENGTH_WIDTH-1:0]     rsp_text_length,
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_write_data
);

   logic [DP_WIDTH-1:0]      decimal_position_ff;
   logic                     blank_leading_ff;

   logic                     s1_valid_ff;
   logic [VALUE_WIDTH-1:0]   s1_value_ff;
   logic                     s2_valid_ff;
   logic [COUNT_WIDTH-1:0]   s2_count_ff;
   logic [COUNT_WIDTH-1:0]   s2_count_in;
   logic                     s3_valid_ff;
   logic [COUNT_WIDTH-1:0]   s3_count_ff;
   logic [3:0]               s3_q1000_ff;
   logic [6:0]               s3_q100_ff;
   logic [9:0]               s3_q10_ff;
   logic [3:0]               s3_q1000_in;
   logic [6:0]               s3_q100_in;
   logic [9:0]               s3_q10_in;

   logic                     rsp_valid_ff;
   logic [CHAR_WIDTH-1:0]    text_0_ff, text_1_ff, text_2_ff, text_3_ff, text_4_ff;
   logic [CHAR_WIDTH-1:0]    text_0_in, text_1_in, text_2_in, text_3_in, text_4_in;
   logic [LENGTH_WIDTH-1:0]  text_length_ff;
   logic [LENGTH_WIDTH-1:0]  text_length_in;

   logic [PRODUCT_WIDTH-1:0] product;
   logic [PRODUCT_WIDTH-1:0] shifted;
   logic [27:0]              prod_1000;
   logic [27:0]              prod_100;
   logic [27:0]              prod_10;
   logic [3:0]               digit [4];
   logic [6:0]               rem_100;
   logic [9:0]               rem_10;
   logic [COUNT_WIDTH-1:0]   rem_1;
   logic [CHAR_WIDTH-1:0]    ch [4];
   logic [3:0]               int_mask;
   logic [3:0]               lead_zero;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         decimal_position_ff <= DP_NONE;
         blank_leading_ff    <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DECIMAL_POSITION: decimal_position_ff <= csr_write_data;
            CSR_BLANK_LEADING:    blank_leading_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Scaling: clamp negative values, multiply by 10^dp, drop the fraction and saturate.
   always_comb begin
      product = PRODUCT_WIDTH'(s1_value_ff[MAG_WIDTH-1:0]) *
                PRODUCT_WIDTH'(scale_of(decimal_position_ff));
      shifted = product >> FRACTION_BITS;
      if (s1_value_ff[VALUE_WIDTH-1]) begin
         s2_count_in = '0;
      end else if (shifted > MAX_COUNT) begin
         s2_count_in = COUNT_WIDTH'(MAX_COUNT);
      end else begin
         s2_count_in = shifted[COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      prod_1000   = 28'(s2_count_ff) * 28'(RECIP_1000);
      prod_100    = 28'(s2_count_ff) * 28'(RECIP_100);
      prod_10     = 28'(s2_count_ff) * 28'(RECIP_10);
      s3_q1000_in = prod_1000[SHIFT_1000 +: 4];
      s3_q100_in  = prod_100[SHIFT_100 +: 7];
      s3_q10_in   = prod_10[SHIFT_10 +: 10];
   end

   always_ff @(posedge clock) begin
      s1_value_ff <= req_value;
      s2_count_ff <= s2_count_in;
      s3_count_ff <= s2_count_ff;
      s3_q1000_ff <= s3_q1000_in;
      s3_q100_ff  <= s3_q100_in;
      s3_q10_ff   <= s3_q10_in;
   end

   always_comb begin
      rem_100  = s3_q100_ff - 7'(s3_q1000_ff) * 7'd10;
      rem_10   = s3_q10_ff - 10'(s3_q100_ff) * 10'd10;
      rem_1    = s3_count_ff - COUNT_WIDTH'(s3_q10_ff) * COUNT_WIDTH'(10);
      digit[0] = s3_q1000_ff;
      digit[1] = rem_100[3:0];
      digit[2] = rem_10[3:0];
      digit[3] = rem_1[3:0];

      // Integer digits other than the last one may be blanked.
      case (decimal_position_ff)
         DP_NONE:  int_mask = 4'b0111;
         DP_ONE:   int_mask = 4'b0011;
         DP_TWO:   int_mask = 4'b0001;
         DP_THREE: int_mask = 4'b0000;
         default:  int_mask = 4'b0111;
      endcase
      lead_zero[0] = (digit[0] == 4'd0);
      lead_zero[1] = lead_zero[0] && (digit[1] == 4'd0);
      lead_zero[2] = lead_zero[1] && (digit[2] == 4'd0);
      lead_zero[3] = lead_zero[2] && (digit[3] == 4'd0);

      for (int i = 0; i < 4; i++) begin
         if (blank_leading_ff && int_mask[i] && lead_zero[i]) begin
            ch[i] = CHAR_SPACE;
         end else begin
            ch[i] = digit_char(digit[i]);
         end
      end

      case (decimal_position_ff)
         DP_ONE: begin
            text_0_in = ch[0];
            text_1_in = ch[1];
            text_2_in = ch[2];
            text_3_in = CHAR_POINT;
            text_4_in = ch[3];
            text_length_in = LENGTH_POINT;
         end
         DP_TWO: begin
            text_0_in = ch[0];
            text_1_in = ch[1];
            text_2_in = CHAR_POINT;
            text_3_in = ch[2];
            text_4_in = ch[3];
            text_length_in = LENGTH_POINT;
         end
         DP_THREE: begin
            text_0_in = ch[0];
            text_1_in = CHAR_POINT;
            text_2_in = ch[1];
            text_3_in = ch[2];
            text_4_in = ch[3];
            text_length_in = LENGTH_POINT;
         end
         default: begin
            text_0_in = ch[0];
            text_1_in = ch[1];
            text_2_in = ch[2];
            text_3_in = ch[3];
            text_4_in = CHAR_NONE;
            text_length_in = LENGTH_PLAIN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      text_0_ff      <= text_0_in;
      text_1_ff      <= text_1_in;
      text_2_ff      <= text_2_in;
      text_3_ff      <= text_3_in;
      text_4_ff      <= text_4_in;
      text_length_ff <= text_length_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_0      = text_0_ff;
   assign rsp_text_1      = text_1_ff;
   assign rsp_text_2      = text_2_ff;
   assign rsp_text_3      = text_3_ff;
   assign rsp_text_4      = text_4_ff;
   assign rsp_text_length = text_length_ff;

endmodule

// ===== verif/fdd_checker.sv =====
// Checker that predicts the display text of every accepted value and compares the results.
module fdd_checker
   import fdd_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          rsp_valid,
   input  logic [CHAR_WIDTH-1:0]         rsp_text_0,
   input  logic [CHAR_WIDTH-1:0]         rsp_text_1,
   input  logic [CHAR_WIDTH-1:0]         rsp_text_2,
   input  logic [CHAR_WIDTH-1:0]         rsp_text_3,
   input  logic [CHAR_WIDTH-1:0]         rsp_text_4,
   input  logic [LENGTH_WIDTH-1:0]       rsp_text_length,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_write_data,
   output int                            mismatch_count,
   output int                            pending_count
);

   typedef struct packed {
      logic [4:0][CHAR_WIDTH-1:0] chars;
      logic [LENGTH_WIDTH-1:0]    length;
   } display_text_type;

   dp_type           fraction_digits;
   logic             blank_leading;
   display_text_type expected_texts [$];
   int               results_seen;

   function automatic display_text_type format_value(
         input logic signed [VALUE_WIDTH-1:0] value,
         input dp_type dp, input logic blank);
      display_text_type text;
      logic [63:0]      scaled;
      int               multiplier;
      int               count;
      int               int_digits;
      int               pos;
      int               digits [4];
      bit               leading;
      case (dp)
         DP_NONE: multiplier = 1;
         DP_ONE:  multiplier = 10;
         DP_TWO:  multiplier = 100;
         default: multiplier = 1000;
      endcase
      // Negative values clamp to zero; large ones saturate at 9999.
      if (value < 0) begin
         count = 0;
      end else begin
         scaled = (64'(value[VALUE_WIDTH-2:0]) * 64'(multiplier)) >> FRACTION_BITS;
         count = (scaled > 64'd9999) ? 9999 : int'(scaled);
      end
      digits[0] = count / 1000;
      digits[1] = (count / 100) % 10;
      digits[2] = (count / 10) % 10;
      digits[3] = count % 10;
      int_digits = 4 - int'(dp);
      text = '0;
      pos = 0;
      leading = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (i < int_digits) begin
            if (leading && digits[i] == 0 && i + 1 != int_digits && blank) begin
               text.chars[pos] = CHAR_SPACE;
            end else begin
               text.chars[pos] = CHAR_ZERO + CHAR_WIDTH'(digits[i]);
            end
            if (digits[i] != 0) begin
               leading = 1'b0;
            end
            pos++;
            if (i + 1 == int_digits && dp != DP_NONE) begin
               text.chars[pos] = CHAR_POINT;
               pos++;
            end
         end else begin
            text.chars[pos] = CHAR_ZERO + CHAR_WIDTH'(digits[i]);
            pos++;
         end
      end
      text.length = LENGTH_WIDTH'(pos);
      return text;
   endfunction

   task automatic report_mismatch(input string message);
      $display("result %0d: %s", results_seen, message);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      display_text_type      due;
      logic [CHAR_WIDTH-1:0] seen [5];
      if (reset) begin
         fraction_digits = DP_NONE;
         blank_leading = 1'b1;
         expected_texts.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_texts.size() == 0) begin
               report_mismatch("transaction arrived with nothing expected");
            end else begin
               due = expected_texts.pop_front();
               seen = '{rsp_text_0, rsp_text_1, rsp_text_2, rsp_text_3, rsp_text_4};
               for (int i = 0; i < 5; i++) begin
                  if (seen[i] !== due.chars[i]) begin
                     report_mismatch($sformatf("text_%0d is 0x%02h, expected 0x%02h",
                                               i, seen[i], due.chars[i]));
                  end
               end
               if (rsp_text_length !== due.length) begin
                  report_mismatch($sformatf("text_length is %0d, expected %0d",
                                            rsp_text_length, due.length));
               end
            end
            results_seen++;
         end
         if (start && !busy) begin
            expected_texts.push_back(format_value(req_value, fraction_digits, blank_leading));
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DECIMAL_POSITION: fraction_digits = dp_type'(csr_write_data);
               CSR_BLANK_LEADING:    blank_leading = csr_write_data[0];
               default: ;
            endcase
         end
      end
      pending_count <= expected_texts.size();
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top that drives values and format settings into the formatter and gives the verdict.
module tb;
   import fdd_pkg::*;

   localparam int STALL_LIMIT = 200;
   localparam int PHASE_ITEMS = 190;
   localparam int PHASES      = 8;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_valid;
   logic [CHAR_WIDTH-1:0]         rsp_text_0;
   logic [CHAR_WIDTH-1:0]         rsp_text_1;
   logic [CHAR_WIDTH-1:0]         rsp_text_2;
   logic [CHAR_WIDTH-1:0]         rsp_text_3;
   logic [CHAR_WIDTH-1:0]         rsp_text_4;
   logic [LENGTH_WIDTH-1:0]       rsp_text_length;
   logic                          csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_write_data;
   int                            mismatch_count;
   int                            pending_count;
   int                            quiet_cycles;
   int                            idle_percent;

   dp_type                    phase_dp [PHASES] = '{DP_THREE, DP_NONE, DP_TWO, DP_ONE,
                                                    DP_NONE, DP_THREE, DP_ONE, DP_TWO};
   logic [CSR_DATA_WIDTH-1:0] phase_blank [PHASES] = '{2'd1, 2'd0, 2'd3, 2'd2,
                                                       2'd1, 2'd0, 2'd1, 2'd0};

   fixed_decimal_display_formatter_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_text_0       (rsp_text_0),
      .rsp_text_1       (rsp_text_1),
      .rsp_text_2       (rsp_text_2),
      .rsp_text_3       (rsp_text_3),
      .rsp_text_4       (rsp_text_4),
      .rsp_text_length  (rsp_text_length),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   fdd_checker results_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_text_0       (rsp_text_0),
      .rsp_text_1       (rsp_text_1),
      .rsp_text_2       (rsp_text_2),
      .rsp_text_3       (rsp_text_3),
      .rsp_text_4       (rsp_text_4),
      .rsp_text_length  (rsp_text_length),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("fixed_decimal_display_formatter_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_format(input dp_type dp, input logic [CSR_DATA_WIDTH-1:0] blank_data);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_DECIMAL_POSITION;
      csr_write_data <= CSR_DATA_WIDTH'(dp);
      @(posedge clock);
      csr_index <= CSR_BLANK_LEADING;
      csr_write_data <= blank_data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value);
      int gap;
      if (idle_percent != 0 && $urandom_range(0, 99) < idle_percent) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_WIDTH-1:0] pick_value(input dp_type dp);
      longint      scale;
      longint      limit;
      int unsigned kind;
      scale = 1;
      repeat (int'(dp)) scale = scale * 10;
      // Smallest value whose scaled count reaches 10000.
      limit = ((longint'(10000) << FRACTION_BITS) + scale - 1) / scale;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         return $urandom;
      end else if (kind < 25) begin
         return {1'b1, 31'($urandom)};
      end else if (kind < 35) begin
         return VALUE_WIDTH'(limit + longint'($urandom_range(0, 16)) - 8);
      end else if (kind < 45) begin
         return VALUE_WIDTH'($urandom_range(0, 32'h1ffff));
      end else if (kind < 55) begin
         return VALUE_WIDTH'((longint'($urandom_range(0, int'(limit >> FRACTION_BITS)))
                              << FRACTION_BITS) + longint'($urandom_range(0, 2)) - 1);
      end
      return VALUE_WIDTH'($urandom_range(0, int'(limit - 1)));
   endfunction

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_value <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_DECIMAL_POSITION;
      csr_write_data <= '0;
      idle_percent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The format left by reset: no point, blanking on.
      send_value(32'sh0000_0000);
      send_value(32'sh0001_0000);
      send_value(32'sh0000_ffff);
      send_value(32'sh270f_0000);
      send_value(32'sh2710_0000);
      send_value(32'shffff_ffff);
      send_value(32'sh8000_0000);
      send_value(32'sh7fff_ffff);
      send_value(32'sh0078_0000);
      send_value(32'sh03ed_0000);

      drain_results();
      set_format(DP_ONE, 2'b10);
      send_value(32'sh7fff_ffff);
      send_value(32'shffff_fffb);
      send_value(32'sh0001_8000);

      drain_results();
      set_format(DP_TWO, 2'b11);
      send_value(32'sh7fff_ffff);
      send_value(32'sh0001_0000);
      send_value(32'sh0000_0290);

      drain_results();
      set_format(DP_THREE, 2'b01);
      send_value(32'sh7fff_ffff);
      send_value(32'sh0000_ffff);
      send_value(32'shffff_ffff);
      send_value(32'sh0009_ffff);
      send_value(32'sh000a_0000);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         set_format(phase_dp[phase], phase_blank[phase]);
         idle_percent = (phase % 3 == 1) ? 45 : ((phase % 3 == 2) ? 10 : 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               drain_results();
            end
            send_value(pick_value(phase_dp[phase]));
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("fixed_decimal_display_formatter_core test passed");
      end else begin
         $display("fixed_decimal_display_formatter_core test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/fdd_pkg.sv
rtl/fixed_decimal_display_formatter_core.sv
verif/fdd_checker.sv
verif/tb.sv
